### rtl/e2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package e2r_pkg;

  localparam int CQ        = 24;
  localparam int STEPS     = 24;
  localparam int FRAC_BITS = 16;
  localparam int ANGLE_W   = 20;
  localparam int OUT_W     = 18;
  localparam int THR_W     = 8;
  localparam int ZW        = 28;
  localparam int XW        = 27;

  localparam logic signed [ZW-1:0] PI_Q      = 28'sd52707179;
  localparam logic signed [ZW-1:0] TWO_PI_Q  = 28'sd105414357;
  localparam logic signed [ZW-1:0] HALF_PI_Q = 28'sd26353589;
  localparam logic signed [XW-1:0] GAIN_Q    = 27'sd10188014;

  localparam logic [1:0] MODE_ZYX = 2'd0;
  localparam logic [1:0] MODE_ZXY = 2'd1;
  localparam logic [1:0] MODE_XYZ = 2'd2;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } e2r_rot_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int i);
    case (i)
      0: atan_q24 = 28'sd13176795;
      1: atan_q24 = 28'sd7778716;
      2: atan_q24 = 28'sd4110060;
      3: atan_q24 = 28'sd2086331;
      4: atan_q24 = 28'sd1047214;
      5: atan_q24 = 28'sd524117;
      6: atan_q24 = 28'sd262123;
      7: atan_q24 = 28'sd131069;
      default: atan_q24 = (i < STEPS) ? ZW'(28'sd1 <<< (24 - i)) : '0;
    endcase
  endfunction

endpackage

### rtl/e2r_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e2r_cordic_cell
// one cordic micro-rotation stage for three angles, registered
// ----------------------------------------------------------------------------
module e2r_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  e2r_pkg::e2r_rot_t     rot_in  [3],
  output e2r_pkg::e2r_rot_t     rot_out [3]
);

  e2r_pkg::e2r_rot_t rot_nxt [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rot_nxt[k].neg = rot_in[k].neg;
      if (!rot_in[k].z[e2r_pkg::ZW-1]) begin
        rot_nxt[k].x = rot_in[k].x - (rot_in[k].y >>> STEP);
        rot_nxt[k].y = rot_in[k].y + (rot_in[k].x >>> STEP);
        rot_nxt[k].z = rot_in[k].z - e2r_pkg::atan_q24(STEP);
      end else begin
        rot_nxt[k].x = rot_in[k].x + (rot_in[k].y >>> STEP);
        rot_nxt[k].y = rot_in[k].y - (rot_in[k].x >>> STEP);
        rot_nxt[k].z = rot_in[k].z + e2r_pkg::atan_q24(STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_out <= rot_nxt;
    end
  end

endmodule

### rtl/euler_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix_core
// euler angles to 3x3 rotation matrix, fully pipelined
// ----------------------------------------------------------------------------
// One angle triple is taken per clock and one matrix leaves per clock. The
// pipe holds two range-reduction stages, a row of 24 cordic cells (one per
// micro-rotation, each holding three angles), a rounding/snap stage, two
// product stages and a sum/saturate stage that loads the output register.
// The whole pipe advances together when the output register is empty or being
// read, so a stall on out_ready freezes every stage. mode 3 yields zeros.
module euler_to_rotation_matrix_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [e2r_pkg::THR_W-1:0]         cfg_zero_snap_threshold,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_mode,
  input  logic signed [e2r_pkg::ANGLE_W-1:0] in_angle_x,
  input  logic signed [e2r_pkg::ANGLE_W-1:0] in_angle_y,
  input  logic signed [e2r_pkg::ANGLE_W-1:0] in_angle_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [e2r_pkg::OUT_W-1:0]  out_elem_r0_c0,
  output logic signed [e2r_pkg::OUT_W-1:0]  out_elem_r0_c1,
  output logic signed [e2r_pkg::OUT_W-1:0]  out_elem_r0_c2,
  output logic signed [e2r_pkg::OUT_W-1:0]  out_elem_r1_c0,
  output logic signed [e2r_pkg::OUT_W-1:0]  out_elem_r1_c1,
  output logic signed [e2r_pkg::OUT_W-1:0]  out_elem_r1_c2,
  output logic signed [e2r_pkg::OUT_W-1:0]  out_elem_r2_c0,
  output logic signed [e2r_pkg::OUT_W-1:0]  out_elem_r2_c1,
  output logic signed [e2r_pkg::OUT_W-1:0]  out_elem_r2_c2
);

  localparam int FRAC_BITS = e2r_pkg::FRAC_BITS;
  localparam int STEPS = e2r_pkg::STEPS;
  localparam int ZW    = e2r_pkg::ZW;
  localparam int XW    = e2r_pkg::XW;
  localparam int SH    = e2r_pkg::CQ - FRAC_BITS;  // may be negative
  localparam int VW    = FRAC_BITS + 2;            // holds +-1.0
  localparam int PW    = 2 * VW;
  localparam int NPRE  = 2;
  localparam int NPOST = 4;                         // snap, p1, p2, sum
  localparam int LAT   = NPRE + STEPS + NPOST;
  localparam logic signed [VW-1:0] ONE = VW'(1) <<< FRAC_BITS;

  // global advance: pipe moves when the output slot frees up
  logic adv;
  logic [LAT-1:0] vld_r, vld_nxt;
  logic [1:0] mode_r [LAT-1];

  logic [e2r_pkg::THR_W-1:0] thr_r;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_valid) begin
      thr_r <= cfg_zero_snap_threshold;
    end
  end

  // ---------------- range reduction ----------------
  logic signed [ZW-1:0] za_nxt [3];
  logic signed [ZW-1:0] za_r   [3];
  e2r_pkg::e2r_rot_t    rot0_nxt [3];
  e2r_pkg::e2r_rot_t    chain [STEPS+1][3];

  function automatic logic signed [ZW-1:0] scale_in(
      input logic signed [e2r_pkg::ANGLE_W-1:0] a);
    logic signed [ZW+31:0] w;
    begin
      w = (ZW+32)'(a);
      if (SH >= 0) w = w <<< SH;
      else         w = w >>> (-SH);
      scale_in = w[ZW-1:0];
    end
  endfunction

  // any 20-bit angle is within +-8 rad, so one 2*pi correction suffices;
  // stage one does the wrap, stage two rechecks it and does the fold
  always_comb begin
    logic signed [ZW-1:0] a [3];
    a[0] = scale_in(in_angle_x);
    a[1] = scale_in(in_angle_y);
    a[2] = scale_in(in_angle_z);
    for (int k = 0; k < 3; k++) begin
      if (a[k] > e2r_pkg::PI_Q)       za_nxt[k] = a[k] - e2r_pkg::TWO_PI_Q;
      else if (a[k] < -e2r_pkg::PI_Q) za_nxt[k] = a[k] + e2r_pkg::TWO_PI_Q;
      else                            za_nxt[k] = a[k];
    end
  end

  always_comb begin
    logic signed [ZW-1:0] z;
    for (int k = 0; k < 3; k++) begin
      z = za_r[k];
      if (z > e2r_pkg::PI_Q)       z = z - e2r_pkg::TWO_PI_Q;
      else if (z < -e2r_pkg::PI_Q) z = z + e2r_pkg::TWO_PI_Q;
      rot0_nxt[k].x   = e2r_pkg::GAIN_Q;
      rot0_nxt[k].y   = '0;
      rot0_nxt[k].neg = 1'b0;
      if (z > e2r_pkg::HALF_PI_Q) begin
        rot0_nxt[k].z   = z - e2r_pkg::PI_Q;
        rot0_nxt[k].neg = 1'b1;
      end else if (z < -e2r_pkg::HALF_PI_Q) begin
        rot0_nxt[k].z   = z + e2r_pkg::PI_Q;
        rot0_nxt[k].neg = 1'b1;
      end else begin
        rot0_nxt[k].z = z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      za_r     <= za_nxt;
      chain[0] <= rot0_nxt;
    end
  end

  // ---------------- cordic cell row ----------------
  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    e2r_cordic_cell #(.STEP(g)) u_cell (
      .clk     (clk),
      .en      (adv),
      .rot_in  (chain[g]),
      .rot_out (chain[g+1])
    );
  end

  // ---------------- round, saturate, snap ----------------
  // index: 0 xs 1 xc 2 ys 3 yc 4 zs 5 zc
  logic signed [VW-1:0] sc_r [6], sc_nxt [6];

  function automatic logic signed [VW-1:0] to_frac(input logic signed [XW-1:0] v,
                                                  input logic [e2r_pkg::THR_W-1:0] t);
    logic signed [XW+32:0] w;
    logic signed [XW+32:0] m;
    logic signed [XW+32:0] one_w;
    begin
      w = (XW+33)'(v);
      if (SH > 0) w = (w + ((XW+33)'(1) <<< (SH - 1))) >>> SH;
      else if (SH < 0) w = w <<< (-SH);
      one_w = (XW+33)'(1) <<< FRAC_BITS;
      if (w > one_w) w = one_w;
      if (w < -one_w) w = -one_w;
      m = w[XW+32] ? -w : w;
      if (m <= (XW+33)'(t)) w = '0;
      to_frac = w[VW-1:0];
    end
  endfunction

  always_comb begin
    e2r_pkg::e2r_rot_t r;
    for (int k = 0; k < 3; k++) begin
      r = chain[STEPS][k];
      sc_nxt[2*k]   = to_frac(r.neg ? -r.y : r.y, thr_r);
      sc_nxt[2*k+1] = to_frac(r.neg ? -r.x : r.x, thr_r);
    end
  end

  // ---------------- products ----------------
  function automatic logic signed [VW-1:0] rmul(input logic signed [VW-1:0] a,
                                               input logic signed [VW-1:0] b);
    logic signed [PW-1:0] p;
    begin
      p = PW'(a) * PW'(b);
      p = (p + (PW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      rmul = p[VW-1:0];
    end
  endfunction

  // stage p1: pair products; stage p2: first factor of triples times third
  logic signed [VW-1:0] s1_r [6], s1_nxt [6];  // forwarded sines/cosines
  logic signed [VW-1:0] q1_r [12], q1_nxt [12];
  logic signed [VW-1:0] q2_r [12], q2_nxt [12];
  logic signed [VW-1:0] s2_r [6];

  // product table per mode: pair (a,b) and triple (a,b,c); idx into sc
  localparam int XS = 0, XC = 1, YS = 2, YC = 3, ZS = 4, ZC = 5;

  always_comb begin
    // pair products (12 slots)
    q1_nxt[0]  = rmul(sc_r[ZC], sc_r[YC]);
    q1_nxt[1]  = rmul(sc_r[ZS], sc_r[XC]);
    q1_nxt[2]  = rmul(sc_r[ZS], sc_r[XS]);
    q1_nxt[3]  = rmul(sc_r[ZS], sc_r[YC]);
    q1_nxt[4]  = rmul(sc_r[ZC], sc_r[XC]);
    q1_nxt[5]  = rmul(sc_r[ZC], sc_r[XS]);
    q1_nxt[6]  = rmul(sc_r[YC], sc_r[XS]);
    q1_nxt[7]  = rmul(sc_r[YC], sc_r[XC]);
    q1_nxt[8]  = rmul(sc_r[ZC], sc_r[YS]);
    q1_nxt[9]  = rmul(sc_r[ZS], sc_r[YS]);
    q1_nxt[10] = rmul(sc_r[ZS], sc_r[XS]);  // zxy triples start zs*xs
    q1_nxt[11] = rmul(sc_r[ZC], sc_r[XS]);  // and zc*xs
    s1_nxt = sc_r;
  end

  always_comb begin
    for (int k = 0; k < 12; k++) q2_nxt[k] = q1_r[k];
    // zyx and xyz triples: (zc*ys)*xs, (zc*ys)*xc, (zs*ys)*xs, (zs*ys)*xc
    q2_nxt[8]  = rmul(q1_r[8],  s1_r[XS]);
    q2_nxt[9]  = rmul(q1_r[8],  s1_r[XC]);
    q2_nxt[10] = rmul(q1_r[9],  s1_r[XS]);
    q2_nxt[11] = rmul(q1_r[9],  s1_r[XC]);
  end

  logic signed [VW-1:0] zxy_r [4], zxy_nxt [4];
  logic signed [VW-1:0] keep_r [4], keep_nxt [4];
  // zs*ys carried from the pair stage for zxy entry r1_c2
  logic signed [VW-1:0] zsys_r;

  always_comb begin
    // zxy triples: (zs*xs)*ys, (zs*xs)*yc, (zc*xs)*ys, (zc*xs)*yc
    zxy_nxt[0] = rmul(q1_r[10], s1_r[YS]);
    zxy_nxt[1] = rmul(q1_r[10], s1_r[YC]);
    zxy_nxt[2] = rmul(q1_r[11], s1_r[YS]);
    zxy_nxt[3] = rmul(q1_r[11], s1_r[YC]);
    keep_nxt[0] = q1_r[2];  // zs*xs
    keep_nxt[1] = q1_r[6];  // yc*xs
    keep_nxt[2] = rmul(s1_r[XC], s1_r[YS]);
    keep_nxt[3] = q1_r[8];  // zc*ys
  end

  // ---------------- sums ----------------
  localparam int SW = VW + 2;
  logic signed [VW-1:0] m_r [9], m_nxt [9];

  function automatic logic signed [VW-1:0] sat(input logic signed [SW-1:0] v);
    begin
      if (v > SW'(ONE))       sat = ONE;
      else if (v < -SW'(ONE)) sat = -ONE;
      else                    sat = v[VW-1:0];
    end
  endfunction

  function automatic logic signed [SW-1:0] ex(input logic signed [VW-1:0] v);
    ex = SW'(v);
  endfunction

  always_comb begin
    for (int k = 0; k < 9; k++) m_nxt[k] = '0;
    case (mode_r[NPRE+STEPS+2])
      e2r_pkg::MODE_ZYX: begin
        m_nxt[0] = sat(ex(q2_r[0]));
        m_nxt[1] = sat(ex(q2_r[1]) + ex(q2_r[8]));
        m_nxt[2] = sat(ex(keep_r[0]) - ex(q2_r[9]));
        m_nxt[3] = sat(-ex(q2_r[3]));
        m_nxt[4] = sat(ex(q2_r[4]) - ex(q2_r[10]));
        m_nxt[5] = sat(ex(q2_r[5]) + ex(q2_r[11]));
        m_nxt[6] = sat(ex(s2_r[YS]));
        m_nxt[7] = sat(-ex(keep_r[1]));
        m_nxt[8] = sat(ex(q2_r[7]));
      end
      e2r_pkg::MODE_ZXY: begin
        m_nxt[0] = sat(ex(q2_r[0]) + ex(zxy_r[0]));
        m_nxt[1] = sat(ex(q2_r[1]));
        m_nxt[2] = sat(-ex(keep_r[3]) + ex(zxy_r[1]));
        m_nxt[3] = sat(-ex(q2_r[3]) + ex(zxy_r[2]));
        m_nxt[4] = sat(ex(q2_r[4]));
        m_nxt[5] = sat(ex(zsys_r) + ex(zxy_r[3]));
        m_nxt[6] = sat(ex(keep_r[2]));
        m_nxt[7] = sat(-ex(s2_r[XS]));
        m_nxt[8] = sat(ex(q2_r[7]));
      end
      e2r_pkg::MODE_XYZ: begin
        m_nxt[0] = sat(ex(q2_r[0]));
        m_nxt[1] = sat(ex(q2_r[3]));
        m_nxt[2] = sat(-ex(s2_r[YS]));
        m_nxt[3] = sat(ex(q2_r[8]) - ex(q2_r[1]));
        m_nxt[4] = sat(ex(q2_r[10]) + ex(q2_r[4]));
        m_nxt[5] = sat(ex(keep_r[1]));
        m_nxt[6] = sat(ex(q2_r[9]) + ex(keep_r[0]));
        m_nxt[7] = sat(ex(q2_r[11]) - ex(q2_r[5]));
        m_nxt[8] = sat(ex(q2_r[7]));
      end
      default: begin
        for (int k = 0; k < 9; k++) m_nxt[k] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_r   <= sc_nxt;
      q1_r   <= q1_nxt;
      s1_r   <= s1_nxt;
      q2_r   <= q2_nxt;
      s2_r   <= s1_r;
      zxy_r  <= zxy_nxt;
      keep_r <= keep_nxt;
      zsys_r <= q1_r[9];
      m_r    <= m_nxt;
    end
  end

  // ---------------- control ----------------
  always_comb begin
    vld_nxt = {vld_r[LAT-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode_r[0] <= in_mode;
      for (int k = 1; k < LAT-1; k++) mode_r[k] <= mode_r[k-1];
    end
  end

  assign out_valid      = vld_r[LAT-1];
  assign out_elem_r0_c0 = e2r_pkg::OUT_W'(m_r[0]);
  assign out_elem_r0_c1 = e2r_pkg::OUT_W'(m_r[1]);
  assign out_elem_r0_c2 = e2r_pkg::OUT_W'(m_r[2]);
  assign out_elem_r1_c0 = e2r_pkg::OUT_W'(m_r[3]);
  assign out_elem_r1_c1 = e2r_pkg::OUT_W'(m_r[4]);
  assign out_elem_r1_c2 = e2r_pkg::OUT_W'(m_r[5]);
  assign out_elem_r2_c0 = e2r_pkg::OUT_W'(m_r[6]);
  assign out_elem_r2_c1 = e2r_pkg::OUT_W'(m_r[7]);
  assign out_elem_r2_c2 = e2r_pkg::OUT_W'(m_r[8]);

  // ---------------- assertions ----------------
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(m_r[0]))
    else $error("result changed while stalled");

  a_ready_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output slot");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipe moved during stall");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (m_r[4] <= ONE) && (m_r[4] >= -ONE))
    else $error("entry beyond unit range");

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the euler angle to rotation matrix pipeline
// ----------------------------------------------------------------------------
// Angle triples go in through a bursty sender. An independent receiver drops
// out_ready on shifting patterns and once for a long hold-off. Every accepted
// triple is run through a bit-true matrix predictor, and the result is queued.
// Each matrix that leaves the block is compared field by field against the
// oldest queued matrix. The snap threshold is rewritten between phases, and
// only while the pipe is empty.
module tb_top;

  localparam int        FB        = e2r_pkg::FRAC_BITS;
  localparam int        LATENCY   = 30;
  localparam logic [1:0] MODE_NONE = 2'd3;   // unused order code, gives zeros
  localparam int        NUM_RAND  = 420;

  typedef logic [9*e2r_pkg::OUT_W-1:0] matrix_t;

  logic                               clk;
  logic                               rst_n;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [e2r_pkg::THR_W-1:0]          cfg_zero_snap_threshold;
  logic                               in_valid;
  logic                               in_ready;
  logic [1:0]                         in_mode;
  logic signed [e2r_pkg::ANGLE_W-1:0] in_angle_x;
  logic signed [e2r_pkg::ANGLE_W-1:0] in_angle_y;
  logic signed [e2r_pkg::ANGLE_W-1:0] in_angle_z;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [e2r_pkg::OUT_W-1:0]   out_elem [9];

  // predictor copy of the snap register
  longint  snap_thr;
  matrix_t matrix_q[$];
  int      mismatch_cnt;
  int      matrix_cnt;
  int      sent_cnt;
  int      burst_left;
  int      mode_seen [4];
  // long receiver hold-off, requested by the test and counted in its own process
  bit      hold_req;
  int      hold_left;

  euler_to_rotation_matrix_core i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_zero_snap_threshold(cfg_zero_snap_threshold),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_mode                (in_mode),
    .in_angle_x             (in_angle_x),
    .in_angle_y             (in_angle_y),
    .in_angle_z             (in_angle_z),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_elem_r0_c0         (out_elem[0]),
    .out_elem_r0_c1         (out_elem[1]),
    .out_elem_r0_c2         (out_elem[2]),
    .out_elem_r1_c0         (out_elem[3]),
    .out_elem_r1_c1         (out_elem[4]),
    .out_elem_r1_c2         (out_elem[5]),
    .out_elem_r2_c0         (out_elem[6]),
    .out_elem_r2_c1         (out_elem[7]),
    .out_elem_r2_c2         (out_elem[8])
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // matrix predictor
  // --------------------------------------------------------------------------
  function automatic longint rnd_shift(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clamp_one(input longint v);
    longint one;
    one = longint'(1) << FB;
    if (v > one) return one;
    if (v < -one) return -one;
    return v;
  endfunction

  // round to Q.16, clamp, then zero anything inside the snap band
  function automatic longint snap_val(input longint v);
    longint m;
    m = clamp_one(rnd_shift(v, e2r_pkg::CQ - FB));
    if ((m < 0 ? -m : m) <= snap_thr) return 0;
    return m;
  endfunction

  function automatic void trig_of(input longint ang, output longint s, output longint c);
    longint atan_tab [24];
    longint z, x, y, dx, dy;
    bit     flip;
    atan_tab = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
                 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
                 256, 128, 64, 32, 16, 8, 4, 2};
    z    = ang * (longint'(1) << (e2r_pkg::CQ - FB));
    flip = 1'b0;
    // wrap into [-pi, pi], then fold the outer half-planes by pi
    while (z > 52707179) z -= 105414357;
    while (z < -52707179) z += 105414357;
    if (z > 26353589) begin
      z -= 52707179;
      flip = 1'b1;
    end else if (z < -26353589) begin
      z += 52707179;
      flip = 1'b1;
    end
    x = 10188014;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = snap_val(y);
    c = snap_val(x);
  endfunction

  function automatic longint mul2(input longint a, input longint b);
    return rnd_shift(a * b, FB);
  endfunction

  function automatic longint mul3(input longint a, input longint b, input longint c);
    return mul2(mul2(a, b), c);
  endfunction

  function automatic matrix_t rotation_of(input logic [1:0] mode,
                                          input logic signed [e2r_pkg::ANGLE_W-1:0] ax,
                                          input logic signed [e2r_pkg::ANGLE_W-1:0] ay,
                                          input logic signed [e2r_pkg::ANGLE_W-1:0] az);
    longint  xs, xc, ys, yc, zs, zc;
    longint  r [9];
    matrix_t m;
    trig_of(longint'(ax), xs, xc);
    trig_of(longint'(ay), ys, yc);
    trig_of(longint'(az), zs, zc);
    for (int k = 0; k < 9; k++) r[k] = 0;
    case (mode)
      e2r_pkg::MODE_ZYX: begin
        r[0] = mul2(zc, yc);
        r[1] = mul2(zs, xc) + mul3(zc, ys, xs);
        r[2] = mul2(zs, xs) - mul3(zc, ys, xc);
        r[3] = -mul2(zs, yc);
        r[4] = mul2(zc, xc) - mul3(zs, ys, xs);
        r[5] = mul2(zc, xs) + mul3(zs, ys, xc);
        r[6] = ys;
        r[7] = -mul2(yc, xs);
        r[8] = mul2(yc, xc);
      end
      e2r_pkg::MODE_ZXY: begin
        r[0] = mul2(yc, zc) + mul3(zs, xs, ys);
        r[1] = mul2(zs, xc);
        r[2] = -mul2(zc, ys) + mul3(zs, xs, yc);
        r[3] = -mul2(zs, yc) + mul3(zc, xs, ys);
        r[4] = mul2(xc, zc);
        r[5] = mul2(zs, ys) + mul3(zc, xs, yc);
        r[6] = mul2(xc, ys);
        r[7] = -xs;
        r[8] = mul2(yc, xc);
      end
      e2r_pkg::MODE_XYZ: begin
        r[0] = mul2(zc, yc);
        r[1] = mul2(zs, yc);
        r[2] = -ys;
        r[3] = mul3(zc, ys, xs) - mul2(zs, xc);
        r[4] = mul3(zs, ys, xs) + mul2(zc, xc);
        r[5] = mul2(yc, xs);
        r[6] = mul3(zc, ys, xc) + mul2(zs, xs);
        r[7] = mul3(zs, ys, xc) - mul2(zc, xs);
        r[8] = mul2(yc, xc);
      end
      default: ;
    endcase
    for (int k = 0; k < 9; k++)
      m[k*e2r_pkg::OUT_W +: e2r_pkg::OUT_W] = e2r_pkg::OUT_W'(clamp_one(r[k]));
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // sender: bursts of random length with random gaps, valid held until taken
  // --------------------------------------------------------------------------
  task automatic send_angles(input logic [1:0] mode,
                             input logic signed [e2r_pkg::ANGLE_W-1:0] ax,
                             input logic signed [e2r_pkg::ANGLE_W-1:0] ay,
                             input logic signed [e2r_pkg::ANGLE_W-1:0] az);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_angle_x <= ax;
    in_angle_y <= ay;
    in_angle_z <= az;
    do @(posedge clk); while (!in_ready);
    matrix_q.push_back(rotation_of(mode, ax, ay, az));
    mode_seen[mode]++;
    sent_cnt++;
  endtask

  // drop valid and wait for a clock edge before anything else drives it
  task automatic end_burst();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  // write the threshold only once the pipe has fully drained
  task automatic write_snap_thr(input logic [e2r_pkg::THR_W-1:0] thr);
    end_burst();
    wait (matrix_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_valid               <= 1'b1;
    cfg_zero_snap_threshold <= thr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    snap_thr  = thr;
  endtask

  function automatic logic signed [e2r_pkg::ANGLE_W-1:0] pick_angle();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 13) return e2r_pkg::ANGLE_W'($urandom_range(0, 823550) - 411775);
    if (sel < 16) return e2r_pkg::ANGLE_W'($urandom);
    // near multiples of pi/2, where the fold and the snap band matter
    return e2r_pkg::ANGLE_W'(int'($urandom_range(0, 8) - 4) * 102944
                             + int'($urandom_range(0, 64)) - 32);
  endfunction

  function automatic logic [1:0] pick_mode();
    if ($urandom_range(0, 15) == 0) return MODE_NONE;
    return 2'($urandom_range(0, 2));
  endfunction

  // --------------------------------------------------------------------------
  // receiver: stall style is redrawn from a tick counter, full-rate stretches included
  // --------------------------------------------------------------------------
  initial begin
    int style;
    int tick;
    style = 0;
    tick  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 300;
      end
      tick++;
      if (tick % 64 == 0) style = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    matrix_t want;
    if (rst_n && out_valid && out_ready) begin
      if (matrix_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("ERROR: matrix out with nothing pending");
      end else begin
        want = matrix_q.pop_front();
        matrix_cnt++;
        for (int k = 0; k < 9; k++) begin
          if (out_elem[k] !== want[k*e2r_pkg::OUT_W +: e2r_pkg::OUT_W]) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("ERROR: matrix %0d elem r%0d_c%0d exp %0d got %0d", matrix_cnt,
                       k / 3, k % 3, $signed(want[k*e2r_pkg::OUT_W +: e2r_pkg::OUT_W]),
                       out_elem[k]);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    logic signed [e2r_pkg::ANGLE_W-1:0] edges [8];
    edges = '{20'sd0, 20'sd411775, -20'sd411775, 20'sd524287, 20'sh80000,
              20'sd102944, -20'sd205887, 20'sd1};
    // every order code against zero angles and the range extremes
    for (int m = 0; m < 4; m++) begin
      send_angles(2'(m), 20'sd0, 20'sd0, 20'sd0);
      send_angles(2'(m), 20'sd411775, -20'sd411775, 20'sd524287);
      send_angles(2'(m), 20'sh80000, 20'sd102944, -20'sd205887);
    end
    // angle beyond two pi on each axis in turn, plus tiny angles
    for (int k = 0; k < 8; k++)
      send_angles(2'(k % 3), edges[k], edges[(k + 3) % 8], edges[(k + 5) % 8]);
    send_angles(e2r_pkg::MODE_XYZ, 20'sd7, -20'sd3, 20'sd102940);
    end_burst();
  endtask

  task automatic test_snap_band(input logic [e2r_pkg::THR_W-1:0] thr);
    write_snap_thr(thr);
    // x angles close to zero and y angles close to a quarter turn give entries near the snap band
    for (int k = 0; k < 12; k++)
      send_angles(2'(k % 4), e2r_pkg::ANGLE_W'(int'($urandom_range(0, 600)) - 300),
                  e2r_pkg::ANGLE_W'(102944 + int'($urandom_range(0, 600)) - 300),
                  pick_angle());
    end_burst();
  endtask

  task automatic test_random(input int count);
    for (int k = 0; k < count; k++)
      send_angles(pick_mode(), pick_angle(), pick_angle(), pick_angle());
    end_burst();
  endtask

  // long receiver hold-off while the sender keeps pushing, so in_ready drops
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int k = 0; k < 80; k++) begin
      burst_left = 1;   // no sender gaps here
      send_angles(pick_mode(), pick_angle(), pick_angle(), pick_angle());
    end
    end_burst();
  endtask

  initial begin
    rst_n                   <= 1'b0;
    cfg_valid               <= 1'b0;
    cfg_zero_snap_threshold <= '0;
    in_valid                <= 1'b0;
    in_mode                 <= e2r_pkg::MODE_ZYX;
    in_angle_x              <= '0;
    in_angle_y              <= '0;
    in_angle_z              <= '0;
    snap_thr     = 0;
    mismatch_cnt = 0;
    matrix_cnt   = 0;
    sent_cnt     = 0;
    burst_left   = 0;
    hold_req     = 1'b0;
    hold_left    = 0;
    for (int m = 0; m < 4; m++) mode_seen[m] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_snap_band(8'd255);
    test_random(NUM_RAND / 4);
    test_snap_band(8'($urandom_range(1, 254)));
    test_random(NUM_RAND / 4);
    test_backpressure();
    test_snap_band(8'd0);
    test_random(NUM_RAND / 4);
    write_snap_thr(8'($urandom_range(1, 40)));
    test_random(NUM_RAND / 4);

    wait (matrix_q.size() == 0);
    repeat (LATENCY + 8) @(posedge clk);
    $display("covered %0d angle triples, %0d matrices checked", sent_cnt, matrix_cnt);
    $display("orders zyx/zxy/xyz/unused %0d/%0d/%0d/%0d, snap threshold 0, 255 and random",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
    if (mismatch_cnt == 0 && matrix_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
